// ===== design/fgns_pkg.sv =====
// ----------------------------------------------------------------------------
// fgns_pkg: shared types and constants for the frontier goal select block
// Request/response payloads, multiply-accumulate command and unit widths.
// ----------------------------------------------------------------------------
`default_nettype none

package fgns_pkg;

   localparam int MAX_CLUSTERS_DEF    = 1024;
   localparam int GRID_INDEX_BITS_DEF = 16;

   localparam int MUL_W  = 25;   // multiplier operand width
   localparam int HALF_W = 24;   // half of the offset magnitude width
   localparam int MAG_W  = 48;   // offset magnitude width
   localparam int OFS_W  = 50;   // signed offset width
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 98;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROBOT_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROBOT_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SIZE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST   = 3'd5;

   typedef enum logic [1:0] {
      SH_0  = 2'd0,
      SH_25 = 2'd1,
      SH_48 = 2'd2
   } shift_type;

   typedef struct packed {
      logic      issue;
      logic      load;
      shift_type shift;
   } mac_cmd_type;

   typedef struct packed {
      logic               operation;
      logic signed [31:0] rep_x;
      logic signed [31:0] rep_y;
      logic [15:0]        rep_row;
      logic [15:0]        rep_col;
      logic signed [31:0] centroid_x;
      logic signed [31:0] centroid_y;
      logic [15:0]        cell_row;
      logic [15:0]        cell_col;
      logic               end_of_cluster;
      logic               end_of_set;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [9:0]         cluster_index;
      logic               accepted;
      logic signed [31:0] goal_x;
      logic signed [31:0] goal_y;
      logic [15:0]        goal_row;
      logic [15:0]        goal_col;
      logic [63:0]        goal_distance_sq;
      logic               last_result;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/frontier_goal_nearest_select_top.sv =====
// ----------------------------------------------------------------------------
// frontier_goal_nearest_select_top: nearest acceptable frontier goal
// Per-cluster verdicts and a final nearest-goal selection over a cluster set.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests arrive on req_* (valid/stall): a cluster header, then its cells.
//    end_of_cluster marks the last item of a cluster, end_of_set the last of
//    the set. Responses leave on rsp_* (valid/stall) from an output register.
//  - csr_* writes robot position, grid origin, cell size and minimum goal
//    distance; write only while the block is idle.
//  - One shared 25x25 multiplier with a 98-bit accumulator does all math.
//    A squared distance sums 6 partial products through the product and
//    accumulator registers. A header takes one squared distance; a cell its
//    center, then one when too close to the robot, two when far enough.
//    Ignored cells skip the unit; a verdict and a final add an output state each.
//  - req_stall is high while an item is in work; one item at a time.
//  - The next request is taken while a response still sits in the output
//    register; a stalled rsp only blocks when a new response must be loaded.
//  - Reset (synchronous, active high) clears the set, the open cluster and
//    control and csr registers to defaults (cell size 13, min distance 256).
// ----------------------------------------------------------------------------
`default_nettype none

module frontier_goal_nearest_select_top import fgns_pkg::*; #(
   parameter int MAX_CLUSTERS    = MAX_CLUSTERS_DEF,
   parameter int GRID_INDEX_BITS = GRID_INDEX_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   localparam int CNT_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_CLUSTERS - 1);
   localparam logic [15:0] IDX_MASK = (GRID_INDEX_BITS >= 16) ? 16'hFFFF :
                                      16'((32'd1 << GRID_INDEX_BITS) - 32'd1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CEN   = 6'b000010,
      ST_SQ    = 6'b000100,
      ST_END   = 6'b001000,
      ST_OUT_V = 6'b010000,
      ST_OUT_F = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      SEL_REP   = 2'd0,
      SEL_RDIST = 2'd1,
      SEL_CDIST = 2'd2
   } sel_type;

   function automatic logic [MAG_W-1:0] mag(input logic signed [OFS_W-1:0] v);
      logic [OFS_W-1:0] a;
      a = v[OFS_W-1] ? -v : v;
      return a[MAG_W-1:0];
   endfunction

   function automatic logic [31:0] half_sat(input logic signed [OFS_W-1:0] v);
      logic signed [OFS_W-2:0] q;
      q = v[OFS_W-1:1];
      if (!q[OFS_W-2] && (|q[OFS_W-3:31])) return 32'h7FFF_FFFF;
      if (q[OFS_W-2] && !(&q[OFS_W-3:31])) return 32'h8000_0000;
      return q[31:0];
   endfunction

   // configuration
   logic [31:0] robot_x_ff, robot_x_in, robot_y_ff, robot_y_in;
   logic [31:0] org_x_ff, org_x_in, org_y_ff, org_y_in;
   logic [15:0] cell_size_ff, cell_size_in;
   logic [31:0] min_sq_ff, min_sq_in;

   // control
   state_type   state_ff, state_in;
   logic [2:0]  step_ff, step_in;
   sel_type     sel_ff, sel_in;
   logic        open_ff, open_in, far_ff, far_in, found_ff, found_in;
   logic        ov_found_ff, ov_found_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // payload
   req_type     item_ff, item_in;
   rsp_type     rsp_ff, rsp_in;
   logic signed [31:0] hdr_x_ff, hdr_x_in, hdr_y_ff, hdr_y_in;
   logic signed [31:0] cen_x_ff, cen_x_in, cen_y_ff, cen_y_in;
   logic [15:0] hdr_row_ff, hdr_row_in, hdr_col_ff, hdr_col_in;
   logic [63:0] hdr_dist_ff, hdr_dist_in;
   logic signed [OFS_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [MAG_W-1:0] sq_a_ff, sq_a_in, sq_b_ff, sq_b_in;
   logic [63:0] rdist_ff, rdist_in;
   logic [63:0] best_d_ff, best_d_in, best_rd_ff, best_rd_in;
   logic signed [OFS_W-1:0] best_cx_ff, best_cx_in, best_cy_ff, best_cy_in;
   logic [15:0] best_row_ff, best_row_in, best_col_ff, best_col_in;
   logic [63:0] ov_d_ff, ov_d_in;
   logic [9:0]  ov_idx_ff, ov_idx_in;
   logic [31:0] ov_x_ff, ov_x_in, ov_y_ff, ov_y_in;
   logic [15:0] ov_row_ff, ov_row_in, ov_col_ff, ov_col_in;

   // shared unit
   mac_cmd_type       mcmd;
   logic [MUL_W-1:0]  mop_a, mop_b;
   logic [ACC_W-1:0]  acc;

   fgns_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mcmd),
      .op_a  (mop_a),
      .op_b  (mop_b),
      .acc   (acc)
   );

   logic signed [OFS_W-1:0] rx1, ry1, rx2, ry2, ox2, oy2, cen2x, cen2y, cyv, cxv;
   logic signed [OFS_W-1:0] prod_s;
   logic [15:0] cell_row_m, cell_col_m;
   logic [63:0] res;
   logic        rsp_free;
   logic [CNT_W+9:0] count_wide;
   logic        v_acc;
   logic [31:0] v_x, v_y;
   logic [15:0] v_row, v_col;
   logic [63:0] v_d;

   assign rx1 = OFS_W'(signed'(robot_x_ff));
   assign ry1 = OFS_W'(signed'(robot_y_ff));
   assign rx2 = rx1 <<< 1;
   assign ry2 = ry1 <<< 1;
   assign ox2 = OFS_W'(signed'(org_x_ff)) <<< 1;
   assign oy2 = OFS_W'(signed'(org_y_ff)) <<< 1;
   assign cen2x = OFS_W'(cen_x_ff) <<< 1;
   assign cen2y = OFS_W'(cen_y_ff) <<< 1;
   assign prod_s = {1'b0, acc[OFS_W-2:0]};
   assign cxv = ox2 + prod_s;
   assign cyv = oy2 + prod_s;
   assign cell_row_m = item_ff.cell_row & IDX_MASK;
   assign cell_col_m = item_ff.cell_col & IDX_MASK;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign count_wide = {10'b0, count_ff};

   // saturating read of the accumulator; robot distance of a cell center
   // drops two fraction bits
   always_comb begin
      if (sel_ff == SEL_RDIST) begin
         res = (|acc[ACC_W-1:66]) ? '1 : acc[65:2];
      end else begin
         res = (|acc[ACC_W-1:64]) ? '1 : acc[63:0];
      end
   end

   // verdict of the open cluster
   always_comb begin
      v_acc = far_ff || found_ff;
      v_x   = hdr_x_ff;
      v_y   = hdr_y_ff;
      v_row = hdr_row_ff;
      v_col = hdr_col_ff;
      v_d   = hdr_dist_ff;
      if (!far_ff && found_ff) begin
         v_x   = half_sat(best_cx_ff);
         v_y   = half_sat(best_cy_ff);
         v_row = best_row_ff;
         v_col = best_col_ff;
         v_d   = best_rd_ff;
      end
   end

   // multiplier operand select
   always_comb begin
      mcmd  = '{issue: 1'b0, load: 1'b0, shift: SH_0};
      mop_a = '0;
      mop_b = '0;
      if (state_ff == ST_CEN && step_ff <= 3'd1) begin
         mcmd  = '{issue: 1'b1, load: 1'b1, shift: SH_0};
         mop_a = (step_ff == 3'd0) ? {8'b0, cell_col_m, 1'b1} : {8'b0, cell_row_m, 1'b1};
         mop_b = {9'b0, cell_size_ff};
      end else if (state_ff == ST_SQ && step_ff <= 3'd5) begin
         mcmd.issue = 1'b1;
         mcmd.load  = (step_ff == 3'd0);
         case (step_ff)
            3'd0: begin
               mop_a = {1'b0, sq_a_ff[HALF_W-1:0]};
               mop_b = {1'b0, sq_a_ff[HALF_W-1:0]};
               mcmd.shift = SH_0;
            end
            3'd1: begin
               mop_a = {1'b0, sq_a_ff[HALF_W-1:0]};
               mop_b = {1'b0, sq_a_ff[MAG_W-1:HALF_W]};
               mcmd.shift = SH_25;
            end
            3'd2: begin
               mop_a = {1'b0, sq_a_ff[MAG_W-1:HALF_W]};
               mop_b = {1'b0, sq_a_ff[MAG_W-1:HALF_W]};
               mcmd.shift = SH_48;
            end
            3'd3: begin
               mop_a = {1'b0, sq_b_ff[HALF_W-1:0]};
               mop_b = {1'b0, sq_b_ff[HALF_W-1:0]};
               mcmd.shift = SH_0;
            end
            3'd4: begin
               mop_a = {1'b0, sq_b_ff[HALF_W-1:0]};
               mop_b = {1'b0, sq_b_ff[MAG_W-1:HALF_W]};
               mcmd.shift = SH_25;
            end
            default: begin
               mop_a = {1'b0, sq_b_ff[MAG_W-1:HALF_W]};
               mop_b = {1'b0, sq_b_ff[MAG_W-1:HALF_W]};
               mcmd.shift = SH_48;
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      robot_x_in   = robot_x_ff;
      robot_y_in   = robot_y_ff;
      org_x_in     = org_x_ff;
      org_y_in     = org_y_ff;
      cell_size_in = cell_size_ff;
      min_sq_in    = min_sq_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ROBOT_X:   robot_x_in   = csr_wdata;
            CSR_ROBOT_Y:   robot_y_in   = csr_wdata;
            CSR_ORIGIN_X:  org_x_in     = csr_wdata;
            CSR_ORIGIN_Y:  org_y_in     = csr_wdata;
            CSR_CELL_SIZE: cell_size_in = csr_wdata[15:0];
            CSR_MIN_DIST:  min_sq_in    = csr_wdata[15:0] * csr_wdata[15:0];
            default: ;
         endcase
      end

      state_in     = state_ff;
      step_in      = step_ff + 3'd1;
      sel_in       = sel_ff;
      open_in      = open_ff;
      far_in       = far_ff;
      found_in     = found_ff;
      ov_found_in  = ov_found_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      item_in      = item_ff;
      rsp_in       = rsp_ff;
      hdr_x_in     = hdr_x_ff;
      hdr_y_in     = hdr_y_ff;
      cen_x_in     = cen_x_ff;
      cen_y_in     = cen_y_ff;
      hdr_row_in   = hdr_row_ff;
      hdr_col_in   = hdr_col_ff;
      hdr_dist_in  = hdr_dist_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      sq_a_in      = sq_a_ff;
      sq_b_in      = sq_b_ff;
      rdist_in     = rdist_ff;
      best_d_in    = best_d_ff;
      best_rd_in   = best_rd_ff;
      best_cx_in   = best_cx_ff;
      best_cy_in   = best_cy_ff;
      best_row_in  = best_row_ff;
      best_col_in  = best_col_ff;
      ov_d_in      = ov_d_ff;
      ov_idx_in    = ov_idx_ff;
      ov_x_in      = ov_x_ff;
      ov_y_in      = ov_y_ff;
      ov_row_in    = ov_row_ff;
      ov_col_in    = ov_col_ff;

      unique case (state_ff)
         ST_IDLE: begin
            step_in = 3'd0;
            if (req_valid) begin
               item_in = req_data;
               if (!req_data.operation) begin
                  hdr_x_in   = req_data.rep_x;
                  hdr_y_in   = req_data.rep_y;
                  hdr_row_in = req_data.rep_row & IDX_MASK;
                  hdr_col_in = req_data.rep_col & IDX_MASK;
                  cen_x_in   = req_data.centroid_x;
                  cen_y_in   = req_data.centroid_y;
                  sq_a_in    = mag(OFS_W'(req_data.rep_x) - rx1);
                  sq_b_in    = mag(OFS_W'(req_data.rep_y) - ry1);
                  sel_in     = SEL_REP;
                  state_in   = ST_SQ;
               end else if (open_ff && !far_ff) begin
                  state_in = ST_CEN;
               end else begin
                  state_in = ST_END;
               end
            end
         end
         ST_CEN: begin
            if (step_ff == 3'd2) begin
               cx_in = cxv;
            end else if (step_ff == 3'd3) begin
               cy_in    = cyv;
               sq_a_in  = mag(cx_ff - rx2);
               sq_b_in  = mag(cyv - ry2);
               sel_in   = SEL_RDIST;
               step_in  = 3'd0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (step_ff == 3'd7) begin
               step_in = 3'd0;
               state_in = ST_END;
               case (sel_ff)
                  SEL_REP: begin
                     hdr_dist_in = res;
                     far_in      = res >= {32'b0, min_sq_ff};
                     found_in    = 1'b0;
                     best_d_in   = '1;
                     best_cx_in  = '0;
                     best_cy_in  = '0;
                     best_row_in = '0;
                     best_col_in = '0;
                     open_in     = 1'b1;
                  end
                  SEL_RDIST: begin
                     if (res >= {32'b0, min_sq_ff}) begin
                        rdist_in = res;
                        sq_a_in  = mag(cx_ff - cen2x);
                        sq_b_in  = mag(cy_ff - cen2y);
                        sel_in   = SEL_CDIST;
                        state_in = ST_SQ;
                     end
                  end
                  default: begin
                     if (!found_ff || res < best_d_ff) begin
                        best_d_in   = res;
                        best_rd_in  = rdist_ff;
                        best_cx_in  = cx_ff;
                        best_cy_in  = cy_ff;
                        best_row_in = cell_row_m;
                        best_col_in = cell_col_m;
                        found_in    = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_END: begin
            if (open_ff && (item_ff.end_of_cluster || item_ff.end_of_set)) begin
               state_in = ST_OUT_V;
            end else if (item_ff.end_of_set) begin
               state_in = ST_OUT_F;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT_V: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{kind: 1'b0, cluster_index: count_wide[9:0], accepted: v_acc,
                          goal_x: v_x, goal_y: v_y, goal_row: v_row, goal_col: v_col,
                          goal_distance_sq: v_d, last_result: !item_ff.end_of_set};
               if (v_acc && (!ov_found_ff || v_d < ov_d_ff)) begin
                  ov_found_in = 1'b1;
                  ov_d_in     = v_d;
                  ov_idx_in   = count_wide[9:0];
                  ov_x_in     = v_x;
                  ov_y_in     = v_y;
                  ov_row_in   = v_row;
                  ov_col_in   = v_col;
               end
               count_in = (count_ff == CNT_LAST) ? '0 : count_ff + CNT_W'(1);
               open_in  = 1'b0;
               state_in = item_ff.end_of_set ? ST_OUT_F : ST_IDLE;
            end
         end
         ST_OUT_F: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (ov_found_ff) begin
                  rsp_in = '{kind: 1'b1, cluster_index: ov_idx_ff, accepted: 1'b1,
                             goal_x: ov_x_ff, goal_y: ov_y_ff, goal_row: ov_row_ff,
                             goal_col: ov_col_ff, goal_distance_sq: ov_d_ff,
                             last_result: 1'b1};
               end else begin
                  rsp_in = '0;
                  rsp_in.kind        = 1'b1;
                  rsp_in.last_result = 1'b1;
               end
               count_in    = '0;
               ov_found_in = 1'b0;
               ov_d_in     = '1;
               ov_idx_in   = '0;
               ov_x_in     = '0;
               ov_y_in     = '0;
               ov_row_in   = '0;
               ov_col_in   = '0;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_ff      <= rsp_in;
      hdr_x_ff    <= hdr_x_in;
      hdr_y_ff    <= hdr_y_in;
      cen_x_ff    <= cen_x_in;
      cen_y_ff    <= cen_y_in;
      hdr_row_ff  <= hdr_row_in;
      hdr_col_ff  <= hdr_col_in;
      hdr_dist_ff <= hdr_dist_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      sq_a_ff     <= sq_a_in;
      sq_b_ff     <= sq_b_in;
      rdist_ff    <= rdist_in;
      best_rd_ff  <= best_rd_in;
      best_cx_ff  <= best_cx_in;
      best_cy_ff  <= best_cy_in;
      best_row_ff <= best_row_in;
      best_col_ff <= best_col_in;
      ov_idx_ff   <= ov_idx_in;
      ov_x_ff     <= ov_x_in;
      ov_y_ff     <= ov_y_in;
      ov_row_ff   <= ov_row_in;
      ov_col_ff   <= ov_col_in;
      if (reset) begin
         robot_x_ff   <= '0;
         robot_y_ff   <= '0;
         org_x_ff     <= '0;
         org_y_ff     <= '0;
         cell_size_ff <= 16'd13;
         min_sq_ff    <= 32'd65536;
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         sel_ff       <= SEL_REP;
         open_ff      <= 1'b0;
         far_ff       <= 1'b0;
         found_ff     <= 1'b0;
         ov_found_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         best_d_ff    <= '1;
         ov_d_ff      <= '1;
      end else begin
         robot_x_ff   <= robot_x_in;
         robot_y_ff   <= robot_y_in;
         org_x_ff     <= org_x_in;
         org_y_ff     <= org_y_in;
         cell_size_ff <= cell_size_in;
         min_sq_ff    <= min_sq_in;
         state_ff     <= state_in;
         step_ff      <= step_in;
         sel_ff       <= sel_in;
         open_ff      <= open_in;
         far_ff       <= far_in;
         found_ff     <= found_in;
         ov_found_ff  <= ov_found_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         best_d_ff    <= best_d_in;
         ov_d_ff      <= ov_d_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== design/fgns_mac.sv =====
// ----------------------------------------------------------------------------
// fgns_mac: shared multiply-accumulate unit
// Registered 25x25 product, then shifted load or add into a 98-bit accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module fgns_mac import fgns_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mac_cmd_type        cmd,
   input  wire logic [MUL_W-1:0]   op_a,
   input  wire logic [MUL_W-1:0]   op_b,
   output logic      [ACC_W-1:0]   acc
);

   logic [PROD_W-1:0] prod_ff, prod_in;
   mac_cmd_type       pend_ff, pend_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  shifted;

   always_comb begin
      prod_in = op_a * op_b;
      pend_in = cmd;
      case (pend_ff.shift)
         SH_25:   shifted = ACC_W'(prod_ff) << 25;
         SH_48:   shifted = ACC_W'(prod_ff) << 48;
         default: shifted = ACC_W'(prod_ff);
      endcase
      acc_in = acc_ff;
      if (pend_ff.issue) begin
         acc_in = pend_ff.load ? shifted : acc_ff + shifted;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

// ===== dv/fgns_checker.sv =====
// ----------------------------------------------------------------------------
// fgns_checker: predictor and scoreboard for the frontier goal select block
// Watches the csr, request and response channels, predicts verdicts and final
// selections, and compares each response field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module fgns_checker import fgns_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire req_type              req_data,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire rsp_type              rsp_data,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata,
   output int                        errors,
   output int                        pending
);

   // configuration copy
   logic signed [31:0] rob_x, rob_y, org_x, org_y;
   logic [15:0]        csize, min_dist;

   // cluster / set state
   logic [9:0]  clu_count;
   logic        clu_open, rep_far, cell_found, set_found;
   longint      hdr_x, hdr_y, cen_x, cen_y;
   logic [15:0] hdr_row, hdr_col;
   logic [63:0] hdr_dist, cell_best_d, set_best_d;
   longint      cell_x2, cell_y2;
   logic [15:0] cell_row, cell_col;
   logic [9:0]  set_idx;
   logic [31:0] set_x, set_y;
   logic [15:0] set_row, set_col;

   rsp_type expected_rsps[$];

   // (a^2 + b^2) >> s, saturating at 64 bits
   function automatic logic [63:0] sq_sum(longint a, longint b, int s);
      logic [127:0] ma, mb, t;
      ma = (a < 0) ? 128'(-a) : 128'(a);
      mb = (b < 0) ? 128'(-b) : 128'(b);
      t = (ma * ma + mb * mb) >> s;
      return (t[127:64] != 0) ? '1 : t[63:0];
   endfunction

   // cell center at twice the coordinate scale
   function automatic longint center2(logic signed [31:0] origin, logic [15:0] idx);
      return 2 * longint'(origin) + (2 * longint'(idx) + 1) * longint'(csize);
   endfunction

   function automatic logic [31:0] half_sat(longint v);
      longint q;
      q = v >>> 1;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
   endfunction

   task automatic clear_set();
      clu_count  = '0;
      set_found  = 1'b0;
      set_best_d = '1;
      set_idx    = '0;
      set_x      = '0;
      set_y      = '0;
      set_row    = '0;
      set_col    = '0;
   endtask

   task automatic predict_request(req_type r);
      logic [63:0] min_sq, d;
      longint      rx, ry, cx, cy, gx, gy;
      logic [15:0] gr, gc;
      logic [63:0] gd;
      logic        acc;
      rsp_type     o;
      int          first;
      min_sq = 64'(min_dist) * 64'(min_dist);
      rx = longint'(rob_x);
      ry = longint'(rob_y);
      first = expected_rsps.size();
      if (!r.operation) begin
         hdr_x    = longint'(r.rep_x);
         hdr_y    = longint'(r.rep_y);
         hdr_row  = r.rep_row;
         hdr_col  = r.rep_col;
         cen_x    = longint'(r.centroid_x);
         cen_y    = longint'(r.centroid_y);
         hdr_dist = sq_sum(hdr_x - rx, hdr_y - ry, 0);
         rep_far  = hdr_dist >= min_sq;
         cell_found  = 1'b0;
         cell_best_d = '1;
         cell_x2  = 0;
         cell_y2  = 0;
         cell_row = '0;
         cell_col = '0;
         clu_open = 1'b1;
      end else if (clu_open && !rep_far) begin
         cx = center2(org_x, r.cell_col);
         cy = center2(org_y, r.cell_row);
         if (sq_sum(cx - 2 * rx, cy - 2 * ry, 2) >= min_sq) begin
            d = sq_sum(cx - 2 * cen_x, cy - 2 * cen_y, 0);
            if (!cell_found || d < cell_best_d) begin
               cell_best_d = d;
               cell_x2  = cx;
               cell_y2  = cy;
               cell_row = r.cell_row;
               cell_col = r.cell_col;
               cell_found = 1'b1;
            end
         end
      end
      if (clu_open && (r.end_of_cluster || r.end_of_set)) begin
         acc = rep_far || cell_found;
         gx = hdr_x; gy = hdr_y; gr = hdr_row; gc = hdr_col; gd = hdr_dist;
         if (!rep_far && cell_found) begin
            gx = longint'($signed(half_sat(cell_x2)));
            gy = longint'($signed(half_sat(cell_y2)));
            gr = cell_row;
            gc = cell_col;
            gd = sq_sum(cell_x2 - 2 * rx, cell_y2 - 2 * ry, 2);
         end
         o = '0;
         o.cluster_index    = clu_count;
         o.accepted         = acc;
         o.goal_x           = gx[31:0];
         o.goal_y           = gy[31:0];
         o.goal_row         = gr;
         o.goal_col         = gc;
         o.goal_distance_sq = gd;
         expected_rsps = {expected_rsps, o};
         if (acc && (!set_found || gd < set_best_d)) begin
            set_found  = 1'b1;
            set_best_d = gd;
            set_idx    = clu_count;
            set_x      = gx[31:0];
            set_y      = gy[31:0];
            set_row    = gr;
            set_col    = gc;
         end
         clu_count = clu_count + 1'b1;
         clu_open  = 1'b0;
      end
      if (r.end_of_set) begin
         o = '0;
         o.kind = 1'b1;
         if (set_found) begin
            o.cluster_index    = set_idx;
            o.accepted         = 1'b1;
            o.goal_x           = set_x;
            o.goal_y           = set_y;
            o.goal_row         = set_row;
            o.goal_col         = set_col;
            o.goal_distance_sq = set_best_d;
         end
         expected_rsps = {expected_rsps, o};
         clear_set();
      end
      if (expected_rsps.size() > first)
         expected_rsps[expected_rsps.size() - 1].last_result = 1'b1;
   endtask

   task automatic cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rob_x = '0; rob_y = '0; org_x = '0; org_y = '0;
         csize = 16'd13;
         min_dist = 16'd256;
         clu_open = 1'b0;
         hdr_x = 0; hdr_y = 0; cen_x = 0; cen_y = 0;
         hdr_row = '0; hdr_col = '0; hdr_dist = '0;
         rep_far = 1'b0;
         cell_found = 1'b0;
         cell_best_d = '1;
         cell_x2 = 0; cell_y2 = 0; cell_row = '0; cell_col = '0;
         clear_set();
         expected_rsps.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ROBOT_X:   rob_x = csr_wdata;
               CSR_ROBOT_Y:   rob_y = csr_wdata;
               CSR_ORIGIN_X:  org_x = csr_wdata;
               CSR_ORIGIN_Y:  org_y = csr_wdata;
               CSR_CELL_SIZE: csize = csr_wdata[15:0];
               CSR_MIN_DIST:  min_dist = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_request(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h",
                        $time, rsp_data);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               cmp("kind", e.kind, rsp_data.kind);
               cmp("cluster_index", e.cluster_index, rsp_data.cluster_index);
               cmp("accepted", e.accepted, rsp_data.accepted);
               cmp("goal_x", e.goal_x, rsp_data.goal_x);
               cmp("goal_y", e.goal_y, rsp_data.goal_y);
               cmp("goal_row", e.goal_row, rsp_data.goal_row);
               cmp("goal_col", e.goal_col, rsp_data.goal_col);
               cmp("goal_distance_sq", e.goal_distance_sq, rsp_data.goal_distance_sq);
               cmp("last_result", e.last_result, rsp_data.last_result);
            end
         end
      end
      pending <= expected_rsps.size();
   end

endmodule

`default_nettype wire

// ===== dv/tb_frontier_goal_nearest_select_top.sv =====
// ----------------------------------------------------------------------------
// tb_frontier_goal_nearest_select_top: testbench for frontier goal select
// Drives cluster sets with random idling on both channels over several csr
// settings; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_frontier_goal_nearest_select_top;
   import fgns_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;
   int                   errors, pending;

   int idle_pct = 35;     // percent of cycles a side idles
   int n_requests = 0;
   int n_sets = 0;

   // tb copy of the csr values, only used to aim stimulus
   logic signed [31:0] rob_x = 0, rob_y = 0, org_x = 0, org_y = 0;
   logic [15:0]        csize = 13, min_dist = 256;

   always #5 clock = ~clock;

   frontier_goal_nearest_select_top dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_write, .csr_index, .csr_wdata
   );

   fgns_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_write, .csr_index, .csr_wdata,
      .errors, .pending
   );

   // receiver back-pressure
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < idle_pct);

   // one request; valid stays high afterward unless a gap lowers it
   task automatic send(req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      n_requests++;
   endtask

   // drain: all expected responses out, then room for ignored-cell work
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_wr(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic configure(logic [31:0] rx, logic [31:0] ry, logic [31:0] ox,
                            logic [31:0] oy, logic [15:0] cs, logic [15:0] md);
      wait_idle();
      rob_x = rx; rob_y = ry; org_x = ox; org_y = oy; csize = cs; min_dist = md;
      csr_wr(CSR_ROBOT_X, rx);
      csr_wr(CSR_ROBOT_Y, ry);
      csr_wr(CSR_ORIGIN_X, ox);
      csr_wr(CSR_ORIGIN_Y, oy);
      csr_wr(CSR_CELL_SIZE, {16'd0, cs});
      csr_wr(CSR_MIN_DIST, {16'd0, md});
   endtask

   function automatic req_type hdr(logic [31:0] x, logic [31:0] y, logic [15:0] row,
                                   logic [15:0] col, logic [31:0] cx, logic [31:0] cy,
                                   logic eoc, logic eos);
      req_type r;
      r = '0;
      r.rep_x = x; r.rep_y = y; r.rep_row = row; r.rep_col = col;
      r.centroid_x = cx; r.centroid_y = cy;
      r.end_of_cluster = eoc; r.end_of_set = eos;
      // junk in the cell fields of a header must not matter
      r.cell_row = $urandom; r.cell_col = $urandom;
      return r;
   endfunction

   function automatic req_type cell_item(logic [15:0] row, logic [15:0] col,
                                         logic eoc, logic eos);
      req_type r;
      r = '0;
      r.operation = 1'b1;
      r.cell_row = row; r.cell_col = col;
      r.end_of_cluster = eoc; r.end_of_set = eos;
      // junk header fields on a cell
      r.rep_x = $urandom; r.rep_y = $urandom; r.centroid_x = $urandom;
      r.rep_row = $urandom; r.centroid_y = $urandom;
      return r;
   endfunction

   // coordinate near a center, mostly within span, sometimes anywhere
   function automatic logic [31:0] near(logic signed [31:0] c, int span);
      if ($urandom_range(9) == 0) return $urandom;
      return c + $signed($urandom_range(2 * span)) - span;
   endfunction

   // grid index near the robot's cell along one axis
   function automatic logic [15:0] near_idx(logic signed [31:0] r, logic signed [31:0] o);
      longint b;
      if ($urandom_range(9) == 0) return $urandom;
      b = (longint'(r) - longint'(o)) / longint'(csize) + int'($urandom_range(24)) - 12;
      if (b < 0) b = 0;
      if (b > 65535) b = 65535;
      return b[15:0];
   endfunction

   // well-formed cluster with random content; rep lands inside the minimum
   // distance less often than outside it
   task automatic rand_cluster(bit last, int max_cells);
      int n, span;
      logic [31:0] cx, cy;
      span = 2 * min_dist + 4;
      n = $urandom_range(max_cells);
      cx = near(rob_x, 8 * span);
      cy = near(rob_y, 8 * span);
      send(hdr(near(rob_x, span), near(rob_y, span), $urandom, $urandom, cx, cy,
               n == 0, last && n == 0));
      for (int i = 0; i < n; i++)
         send(cell_item(near_idx(rob_y, org_y), near_idx(rob_x, org_x),
                        i == n - 1, last && i == n - 1));
   endtask

   // set of clusters, with a little noise: stray cells, abandoned clusters,
   // and a set end that cuts an open cluster short
   task automatic rand_set(int n_clu);
      int k;
      for (int c = 0; c < n_clu; c++) begin
         k = $urandom_range(99);
         if (k < 4)
            send(cell_item($urandom, $urandom, $urandom, 1'b0));
         else if (k < 8)
            send(hdr($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     1'b0, 1'b0));
         else if (k < 11 && c == n_clu - 1) begin
            send(hdr(near(rob_x, 300), near(rob_y, 300), $urandom, $urandom,
                     $urandom, $urandom, 1'b0, 1'b0));
            send(cell_item(near_idx(rob_y, org_y), near_idx(rob_x, org_x), 1'b0, 1'b1));
            n_sets++;
            return;
         end
         rand_cluster(c == n_clu - 1, 6);
      end
      n_sets++;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part, reset settings first ----
      // rep far enough: accepted as is, its cells ignored
      send(hdr(32'd2000, 32'd0, 16'd1, 16'd2, 32'd0, 32'd0, 1'b0, 1'b0));
      send(cell_item(16'd5, 16'd5, 1'b1, 1'b0));
      // rep too close, cells near and far; tie on centroid distance keeps first
      send(hdr(32'd10, 32'd10, 16'd3, 16'd4, 32'd0, 32'd0, 1'b0, 1'b0));
      send(cell_item(16'd0, 16'd0, 1'b0, 1'b0));
      send(cell_item(16'd0, 16'd30, 1'b0, 1'b0));
      send(cell_item(16'd30, 16'd0, 1'b0, 1'b0));
      send(cell_item(16'd0, 16'd30, 1'b1, 1'b0));
      // too close with no far cell
      send(hdr(32'd0, 32'd0, 16'hffff, 16'hffff, 32'd0, 32'd0, 1'b0, 1'b0));
      send(cell_item(16'd0, 16'd0, 1'b1, 1'b0));
      // header with no cells; then a header whose open cluster the next one drops
      send(hdr(32'h8000_0000, 32'h7fff_ffff, 16'd0, 16'd0, 32'd0, 32'd0, 1'b1, 1'b0));
      send(hdr(32'd5, 32'd5, 16'd7, 16'd7, 32'd9, 32'd9, 1'b0, 1'b0));
      // set end inside an open cluster
      send(hdr(32'd1, 32'd1, 16'd8, 16'd8, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0));
      send(cell_item(16'hffff, 16'hffff, 1'b0, 1'b1));
      // stray cell outside a cluster, then a set with no accepted cluster
      send(cell_item(16'd1, 16'd1, 1'b1, 1'b0));
      send(hdr(32'd0, 32'd0, 16'd0, 16'd0, 32'd0, 32'd0, 1'b1, 1'b1));
      // bare set end from a stray cell
      send(cell_item(16'd0, 16'd0, 1'b0, 1'b1));

      // extremes: saturating distances and goal coordinates
      configure(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                16'hffff, 16'hffff);
      send(hdr(32'h8000_0000, 32'h8000_0000, 16'd1, 16'd1, 32'd0, 32'd0, 1'b0, 1'b0));
      send(cell_item(16'hffff, 16'hffff, 1'b0, 1'b0));
      send(cell_item(16'd0, 16'd0, 1'b1, 1'b0));
      send(hdr(32'h7fff_ffff, 32'h7fff_ffff, 16'd2, 16'd2, 32'd0, 32'd0, 1'b1, 1'b1));
      configure(32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h8000_0000, 16'd1, 16'd1);
      send(hdr(32'h7fff_ffff, 32'h0, 16'd1, 16'd1, 32'd0, 32'd0, 1'b0, 1'b0));
      send(cell_item(16'hffff, 16'hffff, 1'b0, 1'b0));
      send(cell_item(16'd0, 16'd0, 1'b1, 1'b1));

      // ---- random part over several settings ----
      configure(0, 0, 0, 0, 16'd13, 16'd256);
      repeat (15) rand_set($urandom_range(1, 6));

      configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      org_x = rob_x - 32'(longint'(csize) * 40);
      org_y = rob_y - 32'(longint'(csize) * 40);
      csr_wr(CSR_ORIGIN_X, org_x);
      csr_wr(CSR_ORIGIN_Y, org_y);
      repeat (15) rand_set($urandom_range(1, 6));

      // stretch with no idling on either side
      idle_pct = 0;
      configure(32'd1000, -32'd2000, -32'd3000, -32'd4000, 16'd64, 16'd1500);
      repeat (15) rand_set($urandom_range(1, 6));
      idle_pct = 35;

      configure(-32'd500, 32'd700, -32'd600, 32'd600, 16'd1, 16'd1);
      repeat (15) rand_set($urandom_range(1, 6));

      // one long set of empty clusters so the cluster index wraps
      configure(0, 0, 0, 0, 16'd200, 16'd400);
      for (int c = 0; c < 1030; c++)
         send(hdr(near(0, 900), near(0, 900), $urandom, $urandom, $urandom, $urandom,
                  1'b1, c == 1029));
      n_sets++;

      wait_idle();
      $display("Covered %0d requests in %0d cluster sets across several csr settings,",
               n_requests, n_sets);
      $display("including saturation extremes and a wrapped cluster index.");
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
